/* hw/rtl/isps_pkg.sv */
`default_nettype none

package isps_pkg;

   // defaults for the top level parameters
   localparam int MAX_DIMS_DEF       = 8;
   localparam int RANGES_PER_DIM_DEF = 16;
   localparam int VALUE_BITS_DEF     = 32;

   localparam int DIM_IDX_W  = 4;
   localparam int STATUS_W   = 3;
   localparam int OUT_VALUE_W = 32;

   localparam logic [DIM_IDX_W-1:0] DIMS_IN_USE_RESET = 4'd8;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GREW_LOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_GREW_HIGH = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEW       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_DIM   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

   // table update broadcast to the cells
   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_MERGE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LOW   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_HIGH  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NEW   = 3'd4;

   // match flags carried along the row of cells
   typedef struct packed {
      logic hit;
      logic below;
      logic above;
      logic free_seen;
   } isps_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/isps_cell.sv */
`default_nettype none

module isps_cell #(
   parameter int MAX_DIMS   = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [isps_pkg::DIM_IDX_W-1:0]     dim,
   input  wire logic signed [VALUE_BITS-1:0]       key,
   input  wire logic signed [VALUE_BITS-1:0]       key_up,
   input  wire logic signed [VALUE_BITS-1:0]       key_dn,
   input  wire logic                               not_max,
   input  wire logic                               not_min,
   input  wire logic                               wr_en,
   input  wire logic [isps_pkg::ACT_W-1:0]         action,
   input  wire logic signed [VALUE_BITS-1:0]       merge_hi,
   input  wire isps_pkg::isps_flags_type           flags_in,
   input  wire logic signed [VALUE_BITS-1:0]       hit_lo_in,
   input  wire logic signed [VALUE_BITS-1:0]       hit_hi_in,
   input  wire logic signed [VALUE_BITS-1:0]       below_hi_in,
   input  wire logic signed [VALUE_BITS-1:0]       above_lo_in,
   output isps_pkg::isps_flags_type                flags_out,
   output logic signed [VALUE_BITS-1:0]            hit_lo_out,
   output logic signed [VALUE_BITS-1:0]            hit_hi_out,
   output logic signed [VALUE_BITS-1:0]            below_hi_out,
   output logic signed [VALUE_BITS-1:0]            above_lo_out
);
   import isps_pkg::*;

   localparam int DimW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   logic signed [VALUE_BITS-1:0] lo_ff [MAX_DIMS];
   logic signed [VALUE_BITS-1:0] hi_ff [MAX_DIMS];
   logic [MAX_DIMS-1:0]          valid_ff;

   logic [DimW-1:0]              sel;
   logic signed [VALUE_BITS-1:0] lo_cur;
   logic signed [VALUE_BITS-1:0] hi_cur;
   logic                         valid_cur;
   logic                         my_hit;
   logic                         my_below;
   logic                         my_above;
   logic                         my_free;

   assign sel       = dim[DimW-1:0];
   assign lo_cur    = lo_ff[sel];
   assign hi_cur    = hi_ff[sel];
   assign valid_cur = valid_ff[sel];

   assign my_hit   = valid_cur && (lo_cur <= key) && (key <= hi_cur);
   assign my_below = valid_cur && not_max && (lo_cur == key_up);
   assign my_above = valid_cur && not_min && (hi_cur == key_dn);
   // first empty slot of the row takes a new range
   assign my_free  = !valid_cur && !flags_in.free_seen;

   always_comb begin
      flags_out.hit       = flags_in.hit | my_hit;
      flags_out.below     = flags_in.below | my_below;
      flags_out.above     = flags_in.above | my_above;
      flags_out.free_seen = flags_in.free_seen | !valid_cur;
      hit_lo_out   = hit_lo_in   | (my_hit   ? lo_cur : '0);
      hit_hi_out   = hit_hi_in   | (my_hit   ? hi_cur : '0);
      below_hi_out = below_hi_in | (my_below ? hi_cur : '0);
      above_lo_out = above_lo_in | (my_above ? lo_cur : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         unique case (action)
            ACT_MERGE: if (my_below) valid_ff[sel] <= 1'b0;
            ACT_NEW:   if (my_free)  valid_ff[sel] <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (action)
            ACT_MERGE: if (my_above) hi_ff[sel] <= merge_hi;
            ACT_LOW:   if (my_below) lo_ff[sel] <= key;
            ACT_HIGH:  if (my_above) hi_ff[sel] <= key;
            ACT_NEW: begin
               if (my_free) begin
                  lo_ff[sel] <= key;
                  hi_ff[sel] <= key;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/interval_set_point_insert_unit.sv */
`default_nettype none

// Point insert into per-dimension sets of disjoint closed ranges.
// Input: raise start with req_dim_index and req_point_value; the beat is
// taken at a clock edge where busy is low. busy then stays high while
// every range slot of that dimension is compared at once.
// Result: rsp_valid is high for exactly one cycle, with rsp_status,
// rsp_range_low and rsp_range_high; accept sets busy_ff, which loads
// rsp_valid_ff and the result registers. The receiver cannot stall; the
// result must be taken in that cycle. A new point waits while busy is
// high, over the row compare that ends in the table write and result load.
// Each cell is one slot position and holds that slot for every dimension;
// match flags and bounds ripple along the row to pick the hit, the
// neighbouring ranges and the first free slot.
// Configuration: csr_dims_in_use is written on csr_valid (always ready);
// write it only while no item is in flight.
// Reset (synchronous, active high): every slot is emptied, dims_in_use
// returns to 8 and nothing is in flight.
module interval_set_point_insert_unit #(
   parameter int MAX_DIMS       = isps_pkg::MAX_DIMS_DEF,
   parameter int RANGES_PER_DIM = isps_pkg::RANGES_PER_DIM_DEF,
   parameter int VALUE_BITS     = isps_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [isps_pkg::DIM_IDX_W-1:0]          req_dim_index,
   input  wire logic signed [isps_pkg::OUT_VALUE_W-1:0] req_point_value,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [isps_pkg::DIM_IDX_W-1:0]          csr_dims_in_use,
   output logic                                         rsp_valid,
   output logic [isps_pkg::STATUS_W-1:0]                rsp_status,
   output logic signed [isps_pkg::OUT_VALUE_W-1:0]      rsp_range_low,
   output logic signed [isps_pkg::OUT_VALUE_W-1:0]      rsp_range_high
);
   import isps_pkg::*;

   localparam logic signed [VALUE_BITS-1:0] KeyMax = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] KeyMin = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [DIM_IDX_W-1:0]         dims_ff;
   logic                         busy_ff;
   logic [DIM_IDX_W-1:0]         dim_ff;
   logic signed [VALUE_BITS-1:0] key_ff;
   logic                         dim_ok_ff;
   logic                         rsp_valid_ff;
   logic [STATUS_W-1:0]          status_ff;
   logic signed [OUT_VALUE_W-1:0] low_ff;
   logic signed [OUT_VALUE_W-1:0] high_ff;

   logic                         accept;
   logic signed [VALUE_BITS-1:0] key_in;
   logic signed [VALUE_BITS-1:0] key_up;
   logic signed [VALUE_BITS-1:0] key_dn;
   logic                         not_max;
   logic                         not_min;
   logic                         dim_ok_in;

   isps_flags_type               flags   [RANGES_PER_DIM+1];
   logic signed [VALUE_BITS-1:0] hit_lo  [RANGES_PER_DIM+1];
   logic signed [VALUE_BITS-1:0] hit_hi  [RANGES_PER_DIM+1];
   logic signed [VALUE_BITS-1:0] blw_hi  [RANGES_PER_DIM+1];
   logic signed [VALUE_BITS-1:0] abv_lo  [RANGES_PER_DIM+1];

   logic [ACT_W-1:0]             action;
   logic [STATUS_W-1:0]          status_in;
   logic signed [VALUE_BITS-1:0] lo_sel;
   logic signed [VALUE_BITS-1:0] hi_sel;
   logic                         wr_en;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign key_in    = VALUE_BITS'(req_point_value);
   assign dim_ok_in = (req_dim_index < dims_ff) &&
                      ({1'b0, req_dim_index} < (DIM_IDX_W+1)'(MAX_DIMS));

   assign key_up  = key_ff + VALUE_BITS'(1);
   assign key_dn  = key_ff - VALUE_BITS'(1);
   assign not_max = key_ff != KeyMax;
   assign not_min = key_ff != KeyMin;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= DIMS_IN_USE_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) dims_ff <= csr_dims_in_use;
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dim_ff    <= req_dim_index;
         key_ff    <= key_in;
         dim_ok_ff <= dim_ok_in;
      end
      if (busy_ff) begin
         status_ff <= status_in;
         low_ff    <= OUT_VALUE_W'(lo_sel);
         high_ff   <= OUT_VALUE_W'(hi_sel);
      end
   end

   assign flags[0]  = '0;
   assign hit_lo[0] = '0;
   assign hit_hi[0] = '0;
   assign blw_hi[0] = '0;
   assign abv_lo[0] = '0;

   for (genvar c = 0; c < RANGES_PER_DIM; c++) begin : g_cell
      isps_cell #(
         .MAX_DIMS   (MAX_DIMS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .dim          (dim_ff),
         .key          (key_ff),
         .key_up       (key_up),
         .key_dn       (key_dn),
         .not_max      (not_max),
         .not_min      (not_min),
         .wr_en        (wr_en),
         .action       (action),
         .merge_hi     (blw_hi[RANGES_PER_DIM]),
         .flags_in     (flags[c]),
         .hit_lo_in    (hit_lo[c]),
         .hit_hi_in    (hit_hi[c]),
         .below_hi_in  (blw_hi[c]),
         .above_lo_in  (abv_lo[c]),
         .flags_out    (flags[c+1]),
         .hit_lo_out   (hit_lo[c+1]),
         .hit_hi_out   (hit_hi[c+1]),
         .below_hi_out (blw_hi[c+1]),
         .above_lo_out (abv_lo[c+1])
      );
   end

   always_comb begin
      action    = ACT_NONE;
      status_in = ST_FULL;
      lo_sel    = '0;
      hi_sel    = '0;
      if (!dim_ok_ff) begin
         status_in = ST_BAD_DIM;
      end else if (flags[RANGES_PER_DIM].hit) begin
         status_in = ST_PRESENT;
         lo_sel    = hit_lo[RANGES_PER_DIM];
         hi_sel    = hit_hi[RANGES_PER_DIM];
      end else if (flags[RANGES_PER_DIM].below && flags[RANGES_PER_DIM].above) begin
         action    = ACT_MERGE;
         status_in = ST_MERGED;
         lo_sel    = abv_lo[RANGES_PER_DIM];
         hi_sel    = blw_hi[RANGES_PER_DIM];
      end else if (flags[RANGES_PER_DIM].below) begin
         action    = ACT_LOW;
         status_in = ST_GREW_LOW;
         lo_sel    = key_ff;
         hi_sel    = blw_hi[RANGES_PER_DIM];
      end else if (flags[RANGES_PER_DIM].above) begin
         action    = ACT_HIGH;
         status_in = ST_GREW_HIGH;
         lo_sel    = abv_lo[RANGES_PER_DIM];
         hi_sel    = key_ff;
      end else if (flags[RANGES_PER_DIM].free_seen) begin
         action    = ACT_NEW;
         status_in = ST_NEW;
         lo_sel    = key_ff;
         hi_sel    = key_ff;
      end
   end

   assign wr_en = busy_ff && dim_ok_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_range_low  = low_ff;
   assign rsp_range_high = high_ff;

endmodule

`default_nettype wire

/* hw/rtl/isps_checker.sv */
`default_nettype none

module isps_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    start,
   input wire logic                                    busy,
   input wire logic                                    rsp_valid,
   input wire logic [isps_pkg::STATUS_W-1:0]           rsp_status,
   input wire logic signed [isps_pkg::OUT_VALUE_W-1:0] rsp_range_low,
   input wire logic signed [isps_pkg::OUT_VALUE_W-1:0] rsp_range_high
);
   import isps_pkg::*;

   // every accepted beat gives a result
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat gave no result");

   // no result without an accepted beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 2))
      else $error("result without an accepted beat");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy missing after accept");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_BAD_DIM || rsp_status == ST_FULL)) |->
      (rsp_range_low == '0 && rsp_range_high == '0))
      else $error("error result carries bounds");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NEW)) |-> (rsp_range_low == rsp_range_high))
      else $error("new range is not a single value");

endmodule

bind interval_set_point_insert_unit isps_checker u_isps_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_range_low  (rsp_range_low),
   .rsp_range_high (rsp_range_high)
);

`default_nettype wire

/* verif/interval_set_point_insert_unit_tb.sv */
`timescale 1ns / 100ps

module interval_set_point_insert_unit_tb;
   import isps_pkg::*;

   localparam int NDIM  = MAX_DIMS_DEF;
   localparam int NSLOT = RANGES_PER_DIM_DEF;

   typedef struct {
      logic [STATUS_W-1:0]           status;
      logic signed [OUT_VALUE_W-1:0] low;
      logic signed [OUT_VALUE_W-1:0] high;
   } insert_outcome_type;

   // shadow of the per-dimension range tables, plus the outcomes still to arrive
   class range_set_tracker;
      logic signed [OUT_VALUE_W-1:0] lo_bound [NDIM][NSLOT];
      logic signed [OUT_VALUE_W-1:0] hi_bound [NDIM][NSLOT];
      bit                            occupied [NDIM][NSLOT];
      logic [DIM_IDX_W-1:0]          dims_active;
      insert_outcome_type            awaited_outcomes[$];
      int                            faults;

      function new();
         dims_active = DIMS_IN_USE_RESET;
         faults = 0;
         foreach (occupied[d, s]) begin
            occupied[d][s] = 1'b0;
            lo_bound[d][s] = '0;
            hi_bound[d][s] = '0;
         end
      endfunction

      function void set_dims(logic [DIM_IDX_W-1:0] n);
         dims_active = n;
      endfunction

      // work out what inserting one point does to the table and what it reports
      function void take_point(logic [DIM_IDX_W-1:0] dim, logic signed [OUT_VALUE_W-1:0] val);
         insert_outcome_type r;
         int below, above, free_slot, hit;
         bit at_max, at_min;
         r.status = ST_BAD_DIM;
         r.low = '0;
         r.high = '0;
         below = -1;
         above = -1;
         free_slot = -1;
         hit = -1;
         if (dim >= dims_active || dim >= NDIM) begin
            awaited_outcomes.insert(awaited_outcomes.size(), r);
            return;
         end
         at_max = (val == 32'sh7fffffff);
         at_min = (val == 32'sh80000000);
         for (int s = 0; s < NSLOT; s++) begin
            if (!occupied[dim][s]) begin
               if (free_slot < 0) free_slot = s;
               continue;
            end
            if (lo_bound[dim][s] <= val && val <= hi_bound[dim][s]) begin
               hit = s;
               break;
            end
            // no wrap-around at the ends of the value range
            if (!at_max && lo_bound[dim][s] == val + 32'sd1) below = s;
            if (!at_min && hi_bound[dim][s] == val - 32'sd1) above = s;
         end
         if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.low = lo_bound[dim][hit];
            r.high = hi_bound[dim][hit];
         end else if (below >= 0 && above >= 0) begin
            hi_bound[dim][above] = hi_bound[dim][below];
            occupied[dim][below] = 1'b0;
            r.status = ST_MERGED;
            r.low = lo_bound[dim][above];
            r.high = hi_bound[dim][above];
         end else if (below >= 0) begin
            lo_bound[dim][below] = val;
            r.status = ST_GREW_LOW;
            r.low = val;
            r.high = hi_bound[dim][below];
         end else if (above >= 0) begin
            hi_bound[dim][above] = val;
            r.status = ST_GREW_HIGH;
            r.low = lo_bound[dim][above];
            r.high = val;
         end else if (free_slot < 0) begin
            r.status = ST_FULL;
         end else begin
            occupied[dim][free_slot] = 1'b1;
            lo_bound[dim][free_slot] = val;
            hi_bound[dim][free_slot] = val;
            r.status = ST_NEW;
            r.low = val;
            r.high = val;
         end
         awaited_outcomes.insert(awaited_outcomes.size(), r);
      endfunction

      function void match_result(logic [STATUS_W-1:0] status,
                                 logic signed [OUT_VALUE_W-1:0] low,
                                 logic signed [OUT_VALUE_W-1:0] high);
         insert_outcome_type e;
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected result beat: status %0d low %0d high %0d", status, low, high);
            faults++;
            return;
         end
         e = awaited_outcomes.pop_front();
         if (status !== e.status) begin
            $error("rsp_status: expected %0d actual %0d", e.status, status);
            faults++;
         end
         if (low !== e.low) begin
            $error("rsp_range_low: expected %0d actual %0d", e.low, low);
            faults++;
         end
         if (high !== e.high) begin
            $error("rsp_range_high: expected %0d actual %0d", e.high, high);
            faults++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [DIM_IDX_W-1:0]          req_dim_index = '0;
   logic signed [OUT_VALUE_W-1:0] req_point_value = '0;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [DIM_IDX_W-1:0]          csr_dims_in_use = '0;
   logic                          rsp_valid;
   logic [STATUS_W-1:0]           rsp_status;
   logic signed [OUT_VALUE_W-1:0] rsp_range_low;
   logic signed [OUT_VALUE_W-1:0] rsp_range_high;

   range_set_tracker              tracker = new();
   logic [DIM_IDX_W-1:0]          dims_setting = DIMS_IN_USE_RESET;
   logic signed [OUT_VALUE_W-1:0] window_base [NDIM];
   bit                            steady_sender = 1'b0;

   interval_set_point_insert_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_dim_index   (req_dim_index),
      .req_point_value (req_point_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_dims_in_use (csr_dims_in_use),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_range_low   (rsp_range_low),
      .rsp_range_high  (rsp_range_high)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("interval_set_point_insert_unit_tb: FAIL");
      $finish;
   end

   // one observer for config writes, accepted points and result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_dims(csr_dims_in_use);
         if (start && !busy) tracker.take_point(req_dim_index, req_point_value);
         if (rsp_valid) tracker.match_result(rsp_status, rsp_range_low, rsp_range_high);
      end
   end

   task automatic send_point(logic [DIM_IDX_W-1:0] dim, logic signed [OUT_VALUE_W-1:0] val);
      int gap;
      gap = 0;
      if (!steady_sender && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_dim_index <= dim;
      req_point_value <= val;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_until_drained(int extra);
      start <= 1'b0;
      do @(posedge clock); while (tracker.awaited_outcomes.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_dims(logic [DIM_IDX_W-1:0] n);
      hold_until_drained(4);
      csr_valid <= 1'b1;
      csr_dims_in_use <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dims_setting = n;
   endtask

   task automatic random_point();
      logic [DIM_IDX_W-1:0] dim;
      logic signed [OUT_VALUE_W-1:0] val;
      int pick, live;
      live = (dims_setting < NDIM) ? dims_setting : NDIM;
      if (live > 0 && $urandom_range(0, 9) < 8) dim = DIM_IDX_W'($urandom_range(0, live - 1));
      else dim = DIM_IDX_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 70)
         val = window_base[dim[2:0]] + $signed($urandom_range(0, 23));
      else if (pick < 80)
         val = $urandom;
      else if (pick < 90)
         val = $urandom_range(0, 1) ? 32'sh7fffffff - $signed($urandom_range(0, 3))
                                    : 32'sh80000000 + $signed($urandom_range(0, 3));
      else
         val = $signed($urandom_range(0, 40)) - 32'sd20;
      send_point(dim, val);
   endtask

   initial begin
      logic [DIM_IDX_W-1:0] phase_dims [7];
      phase_dims = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd0, 4'd8};
      phase_dims[5] = DIM_IDX_W'($urandom_range(0, 15));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // grow, cover, merge within one dimension
      send_point(0, 10);
      send_point(0, 10);
      send_point(0, 11);
      send_point(0, 9);
      send_point(0, 13);
      send_point(0, 12);
      // ends of the value range never join across the wrap
      send_point(1, 32'sh7fffffff);
      send_point(1, 32'sh80000000);
      send_point(1, 32'sh7ffffffe);
      send_point(1, 32'sh80000001);
      // dimension out of range
      send_point(8, 0);
      send_point(15, -1);
      // fill every slot of one dimension, then a lone value that finds it full, an extension and a merge
      for (int i = 0; i < NSLOT; i++) send_point(2, 2 * i);
      send_point(2, 100);
      send_point(2, 31);
      send_point(2, 1);

      for (int p = 0; p < 7; p++) begin
         write_dims(phase_dims[p]);
         foreach (window_base[d])
            window_base[d] = ($urandom_range(0, 3) == 0) ? 32'sh7ffffff0 : $signed($urandom);
         // last stretch of the run goes without sender gaps
         steady_sender = (p == 6);
         for (int n = 0; n < 100; n++) begin
            if (p == 1 && n == 50) hold_until_drained(0);
            random_point();
         end
      end

      hold_until_drained(10);
      if (tracker.faults == 0) begin
         $display("interval_set_point_insert_unit_tb: PASS");
      end else begin
         $display("interval_set_point_insert_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
